@@ hdl/shl_pkg.sv @@
// Shared types and constants for the SPI host link sequencer.
// No dependencies; every other file in hdl/ uses this package.
`timescale 1ns / 1ps

package shl_pkg;

  // Default width of the byte count fields
  localparam int unsigned COUNT_BITS_DEF = 12;

  // Watchdog counter and limit register
  localparam int unsigned WDOG_BITS = 16;
  localparam logic [WDOG_BITS-1:0] WDOG_LIMIT_RST = 16'd16000;
  localparam logic [WDOG_BITS-1:0] WDOG_SAT = 16'hFFFF;

  // Event codes on the input channel
  typedef enum logic [2:0] {
    ACT_IRQ       = 3'd0,
    ACT_DMA_DONE  = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_HOST_DATA = 3'd3,
    ACT_RX_FREED  = 3'd4
  } action_t;

  // Link phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_STATUS   = 4'd1,
    PH_WAIT_RX  = 4'd2,
    PH_RX       = 4'd3,
    PH_WAIT_RXF = 4'd4,
    PH_RXF      = 4'd5,
    PH_WAIT_TX  = 4'd6,
    PH_TX       = 4'd7,
    PH_WAIT_TXF = 4'd8,
    PH_TXF      = 4'd9,
    PH_DUMP     = 4'd10
  } phase_t;

  // DMA command kinds
  typedef enum logic [2:0] {
    DMA_NONE   = 3'd0,
    DMA_STATUS = 3'd1,
    DMA_RX     = 3'd2,
    DMA_RXF    = 3'd3,
    DMA_TX     = 3'd4,
    DMA_TXF    = 3'd5
  } dma_kind_t;

  // Control state of the sequencer, apart from the byte counts
  typedef struct packed {
    phase_t                phase;
    logic                  dog_active;
    logic [WDOG_BITS-1:0]  dog_count;
    logic                  deferred;
  } ctl_state_t;

  // Single-bit strobes of one result beat
  typedef struct packed {
    logic dog_running;
    logic signal_ready;
    logic replay_interrupt;
    logic rx_commit;
    logic wake_task;
    logic lockup;
  } res_flags_t;

endpackage

@@ hdl/shl_stream_if.sv @@
// Valid/ready channel interfaces for the event and result beats.
// Depends on shl_pkg for field types.
`timescale 1ns / 1ps

interface shl_evt_if #(
  parameter int unsigned COUNT_BITS = shl_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [COUNT_BITS-1:0] local_tx_count;
  logic [COUNT_BITS-1:0] local_rx_space;
  logic [COUNT_BITS-1:0] remote_sendable;
  logic [COUNT_BITS-1:0] remote_receivable;
  logic                  status_crc_ok;
  logic                  status_id_ok;
  logic                  footer_crc_ok;

  modport source (
    output valid, action, local_tx_count, local_rx_space, remote_sendable,
           remote_receivable, status_crc_ok, status_id_ok, footer_crc_ok,
    input  ready
  );
  modport sink (
    input  valid, action, local_tx_count, local_rx_space, remote_sendable,
           remote_receivable, status_crc_ok, status_id_ok, footer_crc_ok,
    output ready
  );
endinterface

interface shl_res_if #(
  parameter int unsigned COUNT_BITS = shl_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [3:0]            link_state;
  logic [2:0]            dma_kind;
  logic [COUNT_BITS-1:0] dma_length;
  logic                  watchdog_running;
  logic                  signal_ready;
  logic                  replay_interrupt;
  logic                  rx_commit;
  logic [COUNT_BITS-1:0] rx_commit_len;
  logic [COUNT_BITS-1:0] tx_consume_len;
  logic                  wake_task;
  logic                  lockup;

  modport source (
    output valid, link_state, dma_kind, dma_length, watchdog_running, signal_ready,
           replay_interrupt, rx_commit, rx_commit_len, tx_consume_len, wake_task,
           lockup,
    input  ready
  );
  modport sink (
    input  valid, link_state, dma_kind, dma_length, watchdog_running, signal_ready,
           replay_interrupt, rx_commit, rx_commit_len, tx_consume_len, wake_task,
           lockup,
    output ready
  );
endinterface

@@ hdl/spi_host_link_sequencer.sv @@
// Top level of the SPI host link sequencer: state, result register, config.
// Depends on shl_pkg, shl_stream_if.sv and shl_next.
`timescale 1ns / 1ps

// How to use this block
//   evt: one beat per link event (controller interrupt, DMA done, tick,
//        host data pending, rx space freed) with the local offer, the
//        remote status fields and the CRC verdicts.
//   res: exactly one beat per event: the phase after the event, the DMA
//        command to issue, commit/consume lengths and task/lockup strobes.
//   cfg_we/cfg_wdata: writes the watchdog limit (ticks); write it only
//        while no event is outstanding.
// The result register holds each accepted event's result beat, which shows
// in the cycle after the event is taken. Throughput is one event per cycle
// while the receiver drains results; the single next-state pass between
// the link state registers and the result register sets that rate.
// evt.ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result and
// blocks only further events.
// A synchronous reset puts the link in idle, stops the watchdog, clears
// the counts and any deferred interrupt, and loads the limit with 16000.

module spi_host_link_sequencer #(
  parameter int unsigned COUNT_BITS = shl_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  shl_evt_if.sink                       evt,
  shl_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [shl_pkg::WDOG_BITS-1:0] cfg_wdata
);

  logic [shl_pkg::WDOG_BITS-1:0] wdog_limit;
  shl_pkg::ctl_state_t           ctl;
  shl_pkg::ctl_state_t           ctl_next;
  logic [COUNT_BITS-1:0]         rx_len;
  logic [COUNT_BITS-1:0]         tx_len;
  logic [COUNT_BITS-1:0]         offer_tx;
  logic [COUNT_BITS-1:0]         offer_rx;
  logic [COUNT_BITS-1:0]         rx_len_next;
  logic [COUNT_BITS-1:0]         tx_len_next;
  logic [COUNT_BITS-1:0]         offer_tx_next;
  logic [COUNT_BITS-1:0]         offer_rx_next;
  shl_pkg::dma_kind_t            dma_kind_next;
  logic [COUNT_BITS-1:0]         dma_length_next;
  logic [COUNT_BITS-1:0]         rx_commit_len_next;
  logic [COUNT_BITS-1:0]         tx_consume_len_next;
  shl_pkg::res_flags_t           flags_next;
  logic                          take;

  // Accept when the result register is free or draining
  assign evt.ready = !res.valid || res.ready;
  assign take      = evt.valid && evt.ready;

  shl_next #(
    .COUNT_BITS (COUNT_BITS)
  ) u_next (
    .action            (evt.action),
    .local_tx_count    (evt.local_tx_count),
    .local_rx_space    (evt.local_rx_space),
    .remote_sendable   (evt.remote_sendable),
    .remote_receivable (evt.remote_receivable),
    .status_crc_ok     (evt.status_crc_ok),
    .status_id_ok      (evt.status_id_ok),
    .footer_crc_ok     (evt.footer_crc_ok),
    .wdog_limit        (wdog_limit),
    .ctl               (ctl),
    .rx_len            (rx_len),
    .tx_len            (tx_len),
    .offer_tx          (offer_tx),
    .offer_rx          (offer_rx),
    .ctl_next          (ctl_next),
    .rx_len_next       (rx_len_next),
    .tx_len_next       (tx_len_next),
    .offer_tx_next     (offer_tx_next),
    .offer_rx_next     (offer_rx_next),
    .dma_kind          (dma_kind_next),
    .dma_length        (dma_length_next),
    .rx_commit_len     (rx_commit_len_next),
    .tx_consume_len    (tx_consume_len_next),
    .flags             (flags_next)
  );

  // Watchdog limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      wdog_limit <= shl_pkg::WDOG_LIMIT_RST;
    end else if (cfg_we) begin
      wdog_limit <= cfg_wdata;
    end
  end

  // Link state, updated on every accepted event beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase      <= shl_pkg::PH_IDLE;
      ctl.dog_active <= 1'b0;
      ctl.dog_count  <= '0;
      ctl.deferred   <= 1'b0;
      rx_len         <= '0;
      tx_len         <= '0;
      offer_tx       <= '0;
      offer_rx       <= '0;
    end else if (take) begin
      ctl      <= ctl_next;
      rx_len   <= rx_len_next;
      tx_len   <= tx_len_next;
      offer_tx <= offer_tx_next;
      offer_rx <= offer_rx_next;
    end
  end

  // Result register: valid clears under reset, payload loaded on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.link_state       <= ctl_next.phase;
      res.dma_kind         <= dma_kind_next;
      res.dma_length       <= dma_length_next;
      res.watchdog_running <= flags_next.dog_running;
      res.signal_ready     <= flags_next.signal_ready;
      res.replay_interrupt <= flags_next.replay_interrupt;
      res.rx_commit        <= flags_next.rx_commit;
      res.rx_commit_len    <= rx_commit_len_next;
      res.tx_consume_len   <= tx_consume_len_next;
      res.wake_task        <= flags_next.wake_task;
      res.lockup           <= flags_next.lockup;
    end
  end

  // Core dump is a lock: nothing leaves it short of reset
  a_dump_sticky: assert property (@(posedge clk) disable iff (rst)
    ctl.phase == shl_pkg::PH_DUMP |=> ctl.phase == shl_pkg::PH_DUMP)
    else $error("link left core dump without reset");

  // The watchdog only runs while waiting on the controller
  a_dog_in_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.dog_active |-> (ctl.phase == shl_pkg::PH_IDLE ||
                        ctl.phase == shl_pkg::PH_WAIT_RX ||
                        ctl.phase == shl_pkg::PH_WAIT_RXF ||
                        ctl.phase == shl_pkg::PH_WAIT_TX ||
                        ctl.phase == shl_pkg::PH_WAIT_TXF))
    else $error("watchdog running outside a wait phase");

  // A reported lockup leaves the link in core dump
  a_dump_state: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.lockup |-> res.link_state == shl_pkg::PH_DUMP)
    else $error("lockup strobe without core dump state");

  // Only data DMA commands carry a length
  a_dma_len: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.dma_length != '0 |->
      (res.dma_kind == shl_pkg::DMA_RX || res.dma_kind == shl_pkg::DMA_TX))
    else $error("length on a non-data DMA command");

endmodule

@@ hdl/shl_next.sv @@
// Next-state and result logic for one event of the link sequencer.
// Purely combinational; depends on shl_pkg.
`timescale 1ns / 1ps

module shl_next #(
  parameter int unsigned COUNT_BITS = shl_pkg::COUNT_BITS_DEF
) (
  input  logic [2:0]                     action,
  input  logic [COUNT_BITS-1:0]          local_tx_count,
  input  logic [COUNT_BITS-1:0]          local_rx_space,
  input  logic [COUNT_BITS-1:0]          remote_sendable,
  input  logic [COUNT_BITS-1:0]          remote_receivable,
  input  logic                           status_crc_ok,
  input  logic                           status_id_ok,
  input  logic                           footer_crc_ok,
  input  logic [shl_pkg::WDOG_BITS-1:0]  wdog_limit,
  input  shl_pkg::ctl_state_t            ctl,
  input  logic [COUNT_BITS-1:0]          rx_len,
  input  logic [COUNT_BITS-1:0]          tx_len,
  input  logic [COUNT_BITS-1:0]          offer_tx,
  input  logic [COUNT_BITS-1:0]          offer_rx,
  output shl_pkg::ctl_state_t            ctl_next,
  output logic [COUNT_BITS-1:0]          rx_len_next,
  output logic [COUNT_BITS-1:0]          tx_len_next,
  output logic [COUNT_BITS-1:0]          offer_tx_next,
  output logic [COUNT_BITS-1:0]          offer_rx_next,
  output shl_pkg::dma_kind_t             dma_kind,
  output logic [COUNT_BITS-1:0]          dma_length,
  output logic [COUNT_BITS-1:0]          rx_commit_len,
  output logic [COUNT_BITS-1:0]          tx_consume_len,
  output shl_pkg::res_flags_t            flags
);

  logic [COUNT_BITS-1:0]         rx_min;
  logic [COUNT_BITS-1:0]         tx_min;
  logic [shl_pkg::WDOG_BITS-1:0] dog_inc;

  // Negotiated counts from the status exchange
  assign rx_min = (offer_rx < remote_sendable) ? offer_rx : remote_sendable;
  assign tx_min = (offer_tx < remote_receivable) ? offer_tx : remote_receivable;

  // Saturating watchdog increment
  assign dog_inc = (ctl.dog_count != shl_pkg::WDOG_SAT) ?
                   ctl.dog_count + 1'b1 : ctl.dog_count;

  always_comb begin
    ctl_next       = ctl;
    rx_len_next    = rx_len;
    tx_len_next    = tx_len;
    offer_tx_next  = offer_tx;
    offer_rx_next  = offer_rx;
    dma_kind       = shl_pkg::DMA_NONE;
    dma_length     = '0;
    rx_commit_len  = '0;
    tx_consume_len = '0;
    flags          = '0;

    unique case (shl_pkg::action_t'(action))
      // Controller interrupt: always stops the watchdog
      shl_pkg::ACT_IRQ: begin
        ctl_next.dog_active = 1'b0;
        unique case (ctl.phase)
          shl_pkg::PH_IDLE: begin
            if (local_rx_space == '0) begin
              ctl_next.deferred = 1'b1;
            end else begin
              offer_tx_next  = local_tx_count;
              offer_rx_next  = local_rx_space;
              ctl_next.phase = shl_pkg::PH_STATUS;
              dma_kind       = shl_pkg::DMA_STATUS;
            end
          end
          shl_pkg::PH_WAIT_RX: begin
            ctl_next.phase = shl_pkg::PH_RX;
            dma_kind       = shl_pkg::DMA_RX;
            dma_length     = rx_len;
          end
          shl_pkg::PH_WAIT_RXF: begin
            ctl_next.phase = shl_pkg::PH_RXF;
            dma_kind       = shl_pkg::DMA_RXF;
          end
          shl_pkg::PH_WAIT_TX: begin
            ctl_next.phase = shl_pkg::PH_TX;
            dma_kind       = shl_pkg::DMA_TX;
            dma_length     = tx_len;
          end
          shl_pkg::PH_WAIT_TXF: begin
            ctl_next.phase = shl_pkg::PH_TXF;
            dma_kind       = shl_pkg::DMA_TXF;
          end
          // Interrupt while a DMA is in flight is a protocol fault
          shl_pkg::PH_STATUS, shl_pkg::PH_RX, shl_pkg::PH_RXF,
          shl_pkg::PH_TX, shl_pkg::PH_TXF: begin
            ctl_next.phase  = shl_pkg::PH_DUMP;
            flags.lockup    = 1'b1;
            flags.wake_task = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // DMA completion advances the DMA phases
      shl_pkg::ACT_DMA_DONE: begin
        unique case (ctl.phase)
          shl_pkg::PH_STATUS: begin
            if (!status_crc_ok || !status_id_ok) begin
              ctl_next.phase  = shl_pkg::PH_DUMP;
              flags.lockup    = 1'b1;
              flags.wake_task = 1'b1;
            end else begin
              rx_len_next = rx_min;
              tx_len_next = tx_min;
              if (rx_min != '0) begin
                if (!ctl.dog_active) begin
                  ctl_next.dog_count = '0;
                end
                ctl_next.dog_active = 1'b1;
                ctl_next.phase      = shl_pkg::PH_WAIT_RX;
              end else begin
                flags.rx_commit = 1'b1;
                if (tx_min != '0) begin
                  if (!ctl.dog_active) begin
                    ctl_next.dog_count = '0;
                  end
                  ctl_next.dog_active = 1'b1;
                  ctl_next.phase      = shl_pkg::PH_WAIT_TX;
                end else begin
                  ctl_next.phase = shl_pkg::PH_IDLE;
                end
              end
            end
          end
          shl_pkg::PH_RX, shl_pkg::PH_TX: begin
            if (!ctl.dog_active) begin
              ctl_next.dog_count = '0;
            end
            ctl_next.dog_active = 1'b1;
            ctl_next.phase = (ctl.phase == shl_pkg::PH_RX) ?
                             shl_pkg::PH_WAIT_RXF : shl_pkg::PH_WAIT_TXF;
          end
          shl_pkg::PH_RXF: begin
            flags.rx_commit = 1'b1;
            rx_commit_len   = rx_len;
            if (!footer_crc_ok) begin
              ctl_next.phase  = shl_pkg::PH_DUMP;
              flags.lockup    = 1'b1;
              flags.wake_task = 1'b1;
            end else if (tx_len != '0) begin
              if (!ctl.dog_active) begin
                ctl_next.dog_count = '0;
              end
              ctl_next.dog_active = 1'b1;
              ctl_next.phase      = shl_pkg::PH_WAIT_TX;
            end else begin
              ctl_next.phase  = shl_pkg::PH_IDLE;
              flags.wake_task = 1'b1;
            end
          end
          shl_pkg::PH_TXF: begin
            ctl_next.phase  = shl_pkg::PH_IDLE;
            tx_consume_len  = tx_len;
            flags.wake_task = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // Watchdog tick; a limit of zero fires on the first tick
      shl_pkg::ACT_TICK: begin
        if (ctl.dog_active) begin
          ctl_next.dog_count = dog_inc;
          if (dog_inc >= wdog_limit) begin
            ctl_next.dog_active = 1'b0;
            ctl_next.phase      = shl_pkg::PH_DUMP;
            flags.lockup        = 1'b1;
            flags.wake_task     = 1'b1;
          end
        end
      end

      // Host has data: raise the ready line and guard the wait
      shl_pkg::ACT_HOST_DATA: begin
        if (ctl.phase == shl_pkg::PH_IDLE) begin
          if (!ctl.dog_active) begin
            ctl_next.dog_count = '0;
          end
          ctl_next.dog_active = 1'b1;
          flags.signal_ready  = 1'b1;
        end
      end

      // Receive space freed: replay a deferred interrupt
      shl_pkg::ACT_RX_FREED: begin
        if (ctl.deferred) begin
          ctl_next.deferred      = 1'b0;
          flags.replay_interrupt = 1'b1;
        end
      end

      default: begin
      end
    endcase

    flags.dog_running = ctl_next.dog_active;
  end

endmodule
